// ----- rtl/inversive_congruential_prng_top_defines.svh -----
// Assertion macros shared by the generator RTL.
`ifndef INVERSIVE_CONGRUENTIAL_PRNG_TOP_DEFINES_SVH
`define INVERSIVE_CONGRUENTIAL_PRNG_TOP_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define ICP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ICP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/icp_pkg.sv -----
// Shared widths, reset values and codes of the inversive congruential generator.
`timescale 1ns / 1ps

package icp_pkg;

    localparam int unsigned WORD_W    = 31;
    localparam int unsigned SEED_W    = 64;
    localparam int unsigned VALUE_W   = 63;
    localparam int unsigned PROD_W    = 2 * WORD_W;
    localparam int unsigned RED_CNT_W = 6;
    localparam int unsigned SHIFT_W   = 5;
    localparam int unsigned REQ_W     = 2;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] MODULUS_RST = 31'd2147483647;
    localparam logic [WORD_W-1:0] MULT_RST    = 31'd9102;
    localparam logic [WORD_W-1:0] INC_RST     = 31'd2110582212;
    localparam logic [WORD_W-1:0] MODULUS_MIN = 31'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_SEED = 2'd0,
        REQ_DRAW = 2'd1,
        REQ_PAIR = 2'd2
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS    = 2'd0,
        CFG_MULTIPLIER = 2'd1,
        CFG_INCREMENT  = 2'd2
    } cfg_idx_t;

endpackage

// ----- rtl/inversive_congruential_prng_top.sv -----
// Inversive congruential generator: seed load and draws over a configurable modulus.
// Seed load: a 64-step remainder, after which the next request is taken.
// Draw step: Euclid rounds of the inverse, then multiply, add and the 64-step remainder;
// a zero state skips the Euclid rounds, and a pair runs the draw step twice.
// Reset clears the state to 0 and restores modulus, multiplier and increment defaults.
`timescale 1ns / 1ps

`include "inversive_congruential_prng_top_defines.svh"

module inversive_congruential_prng_top
    import icp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // request channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [REQ_W-1:0]          req_type,
    input  logic signed [SEED_W-1:0]  seed,
    // result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [VALUE_W-1:0]        value,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [WORD_W-1:0]         cfg_data
);

    // Sequencer. One shared mod-m double-and-add unit serves both the
    // bit-serial remainder (seed and product reduction) and the Horner
    // accumulation of each Euclidean quotient times the coefficient.
    typedef enum logic [3:0] {
        S_IDLE,
        S_INV_INIT,
        S_INV_ALIGN,
        S_INV_DIV,
        S_INV_SWAP,
        S_MUL,
        S_ADD,
        S_RED,
        S_EMIT
    } fsm_t;

    // control and configuration, cleared by reset
    fsm_t                   fsm_reg, fsm_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [WORD_W-1:0]      cur_state_reg, cur_state_next;
    logic [WORD_W-1:0]      m_reg, m_next;
    logic [WORD_W-1:0]      mult_reg, mult_next;
    logic [WORD_W-1:0]      inc_reg, inc_next;
    logic                   seed_mode_reg, seed_mode_next;
    logic                   pair_reg, pair_next;
    logic                   second_reg, second_next;
    logic [RED_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SHIFT_W-1:0]     k_reg, k_next;

    // datapath, loaded before use
    logic [WORD_W-1:0]      red_rem_reg, red_rem_next;
    logic [SEED_W-1:0]      red_div_reg, red_div_next;
    logic                   neg_reg, neg_next;
    logic [WORD_W-1:0]      rem_reg, rem_next;
    logic [WORD_W-1:0]      nrem_reg, nrem_next;
    logic [WORD_W-1:0]      co_reg, co_next;
    logic [WORD_W-1:0]      nco_reg, nco_next;
    logic [WORD_W-1:0]      d_reg, d_next;
    logic [WORD_W-1:0]      acc_reg, acc_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [WORD_W-1:0]      hi_reg, hi_next;
    logic [VALUE_W-1:0]     result_reg, result_next;

    // shared modular unit: ((2*base + bit) mod m + add) mod m, base and add below m
    logic [WORD_W-1:0]      mu_base;
    logic                   mu_bit;
    logic [WORD_W-1:0]      mu_add;
    logic [WORD_W:0]        mu_t1;
    logic [WORD_W-1:0]      mu_r1;
    logic [WORD_W:0]        mu_t2;
    logic [WORD_W-1:0]      mu_res;

    // Euclid helpers
    logic                   div_ge;
    logic [WORD_W:0]        co_diff;
    logic [WORD_W-1:0]      tc;
    logic [SEED_W-1:0]      seed_u;
    logic [SEED_W-1:0]      seed_mag;

    assign in_stall  = (fsm_reg != S_IDLE);
    assign cfg_ready = (fsm_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    assign seed_u   = $unsigned(seed);
    assign seed_mag = seed_u[SEED_W-1] ? (~seed_u + SEED_W'(1)) : seed_u;

    assign div_ge  = (rem_reg >= d_reg);
    assign co_diff = {1'b0, co_reg} - {1'b0, acc_reg};
    assign tc      = co_diff[WORD_W] ? WORD_W'(co_diff[WORD_W-1:0] + m_reg)
                                     : co_diff[WORD_W-1:0];

    // select operands of the shared unit
    always_comb
    begin
        mu_base = red_rem_reg;
        mu_bit  = red_div_reg[SEED_W-1];
        mu_add  = '0;
        if (fsm_reg == S_INV_DIV)
        begin
            mu_base = acc_reg;
            mu_bit  = 1'b0;
            mu_add  = div_ge ? nco_reg : '0;
        end
    end

    always_comb
    begin
        mu_t1  = {mu_base, mu_bit};
        mu_r1  = (mu_t1 >= {1'b0, m_reg}) ? WORD_W'(mu_t1 - {1'b0, m_reg})
                                          : mu_t1[WORD_W-1:0];
        mu_t2  = {1'b0, mu_r1} + {1'b0, mu_add};
        mu_res = (mu_t2 >= {1'b0, m_reg}) ? WORD_W'(mu_t2 - {1'b0, m_reg})
                                          : mu_t2[WORD_W-1:0];
    end

    // next-state logic
    always_comb
    begin
        fsm_next       = fsm_reg;
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        cur_state_next = cur_state_reg;
        m_next         = m_reg;
        mult_next      = mult_reg;
        inc_next       = inc_reg;
        seed_mode_next = seed_mode_reg;
        pair_next      = pair_reg;
        second_next    = second_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        red_rem_next   = red_rem_reg;
        red_div_next   = red_div_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        nrem_next      = nrem_reg;
        co_next        = co_reg;
        nco_next       = nco_reg;
        d_next         = d_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        hi_next        = hi_reg;
        result_next    = result_reg;

        // configuration transfer; a modulus below 2 acts as 2
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODULUS:    m_next    = (cfg_data < MODULUS_MIN) ? MODULUS_MIN : cfg_data;
                CFG_MULTIPLIER: mult_next = cfg_data;
                CFG_INCREMENT:  inc_next  = cfg_data;
                default:        ;
            endcase
        end

        case (fsm_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_type)
                        REQ_SEED:
                        begin
                            // reduce the magnitude, fix the sign at the end
                            seed_mode_next = 1'b1;
                            neg_next       = seed_u[SEED_W-1];
                            red_div_next   = seed_mag;
                            red_rem_next   = '0;
                            cnt_next       = '1;
                            fsm_next       = S_RED;
                        end
                        REQ_DRAW:
                        begin
                            seed_mode_next = 1'b0;
                            pair_next      = 1'b0;
                            second_next    = 1'b0;
                            fsm_next       = S_INV_INIT;
                        end
                        REQ_PAIR:
                        begin
                            seed_mode_next = 1'b0;
                            pair_next      = 1'b1;
                            second_next    = 1'b0;
                            fsm_next       = S_INV_INIT;
                        end
                        default: ;  // unused code: drop the request
                    endcase
                end
            end
            S_INV_INIT:
            begin
                if (cur_state_reg == '0)
                begin
                    co_next  = '0;
                    fsm_next = S_MUL;
                end
                else
                begin
                    rem_next  = m_reg;
                    nrem_next = cur_state_reg;
                    co_next   = '0;
                    nco_next  = WORD_W'(1);
                    d_next    = cur_state_reg;
                    acc_next  = '0;
                    k_next    = '0;
                    fsm_next  = S_INV_ALIGN;
                end
            end
            S_INV_ALIGN:
            begin
                // shift the divisor up to the top of the remainder
                if ({d_reg, 1'b0} <= {1'b0, rem_reg})
                begin
                    d_next = {d_reg[WORD_W-2:0], 1'b0};
                    k_next = k_reg + SHIFT_W'(1);
                end
                else
                begin
                    fsm_next = S_INV_DIV;
                end
            end
            S_INV_DIV:
            begin
                // one quotient bit; fold it into q*nco mod m
                if (div_ge)
                begin
                    rem_next = rem_reg - d_reg;
                end
                acc_next = mu_res;
                d_next   = {1'b0, d_reg[WORD_W-1:1]};
                if (k_reg == '0)
                begin
                    fsm_next = S_INV_SWAP;
                end
                else
                begin
                    k_next = k_reg - SHIFT_W'(1);
                end
            end
            S_INV_SWAP:
            begin
                rem_next  = nrem_reg;
                nrem_next = rem_reg;
                co_next   = nco_reg;
                nco_next  = tc;
                if (rem_reg == '0)
                begin
                    fsm_next = S_MUL;
                end
                else
                begin
                    d_next   = rem_reg;
                    acc_next = '0;
                    k_next   = '0;
                    fsm_next = S_INV_ALIGN;
                end
            end
            S_MUL:
            begin
                prod_next = PROD_W'(mult_reg) * PROD_W'(co_reg);
                fsm_next  = S_ADD;
            end
            S_ADD:
            begin
                red_div_next = SEED_W'(prod_reg) + SEED_W'(inc_reg);
                red_rem_next = '0;
                cnt_next     = '1;
                fsm_next     = S_RED;
            end
            S_RED:
            begin
                red_rem_next = mu_res;
                red_div_next = {red_div_reg[SEED_W-2:0], 1'b0};
                cnt_next     = cnt_reg - RED_CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    if (seed_mode_reg)
                    begin
                        cur_state_next = (neg_reg && (mu_res != '0)) ? m_reg - mu_res : mu_res;
                        fsm_next       = S_IDLE;
                    end
                    else
                    begin
                        cur_state_next = mu_res;
                        if (pair_reg && !second_reg)
                        begin
                            hi_next     = mu_res;
                            second_next = 1'b1;
                            fsm_next    = S_INV_INIT;
                        end
                        else
                        begin
                            result_next = pair_reg ? {hi_reg, 1'b0, mu_res}
                                                   : VALUE_W'(mu_res);
                            fsm_next    = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    value_next     = result_reg;
                    fsm_next       = S_IDLE;
                end
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    // sequencer state, registered outputs and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            cur_state_reg <= '0;
            m_reg         <= MODULUS_RST;
            mult_reg      <= MULT_RST;
            inc_reg       <= INC_RST;
            seed_mode_reg <= 1'b0;
            pair_reg      <= 1'b0;
            second_reg    <= 1'b0;
            cnt_reg       <= '0;
            k_reg         <= '0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            out_valid_reg <= out_valid_next;
            value_reg     <= value_next;
            cur_state_reg <= cur_state_next;
            m_reg         <= m_next;
            mult_reg      <= mult_next;
            inc_reg       <= inc_next;
            seed_mode_reg <= seed_mode_next;
            pair_reg      <= pair_next;
            second_reg    <= second_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
        end
    end

    // arithmetic datapath
    always_ff @(posedge clk)
    begin
        red_rem_reg <= red_rem_next;
        red_div_reg <= red_div_next;
        neg_reg     <= neg_next;
        rem_reg     <= rem_next;
        nrem_reg    <= nrem_next;
        co_reg      <= co_next;
        nco_reg     <= nco_next;
        d_reg       <= d_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        hi_reg      <= hi_next;
        result_reg  <= result_next;
    end

    `ICP_ASSERT_NOW(a_mod_floor, 1'b1, m_reg >= MODULUS_MIN, "modulus below floor")
    `ICP_ASSERT_NEXT(a_seed_range, (fsm_reg == S_RED) && (cnt_reg == '0) && seed_mode_reg, cur_state_reg < m_reg, "seeded state not below modulus")
    `ICP_ASSERT_NOW(a_coef_range, fsm_reg == S_INV_DIV, (acc_reg < m_reg) && (nco_reg < m_reg), "coefficient not reduced")
    `ICP_ASSERT_NOW(a_div_nonzero, fsm_reg == S_INV_DIV, d_reg != '0, "zero divisor in Euclid step")

endmodule

// ----- tb/inversive_congruential_prng_top_tb.sv -----
// Self-checking testbench of the inversive congruential generator: directed and random requests.
`timescale 1ns / 1ps

module inversive_congruential_prng_top_tb
    import icp_pkg::*;
();

    // Request code the block must ignore, and a register index it must ignore.
    localparam logic [REQ_W-1:0]     REQ_NONE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int GAP_MAX         = 14;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int QUIET_LIMIT     = 20000;
    // A seed load runs with no result to show for it.
    localparam int SETTLE_CYCLES   = 200;
    localparam int END_WAIT        = 1000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 145;

    typedef struct {
        logic [REQ_W-1:0]         kind;
        logic signed [SEED_W-1:0] seed;
    } request_t;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [REQ_W-1:0]         req_type  = REQ_SEED;
    logic signed [SEED_W-1:0] seed      = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b1;
    logic [VALUE_W-1:0]       value;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_MODULUS;
    logic [WORD_W-1:0]        cfg_data  = '0;

    // Generator copy: configuration and state as the block should hold them.
    logic [WORD_W-1:0] mod_reg   = MODULUS_RST;
    logic [WORD_W-1:0] mult_reg  = MULT_RST;
    logic [WORD_W-1:0] inc_reg   = INC_RST;
    logic [WORD_W-1:0] gen_state = '0;

    request_t           request_queue[$];
    logic [VALUE_W-1:0] expected_values[$];

    int  queued       = 0;
    int  accepted     = 0;
    int  results_seen = 0;
    int  errors       = 0;
    int  quiet        = 0;
    logic in_took     = 1'b0;
    logic out_took    = 1'b0;
    logic hold_off    = 1'b0;

    inversive_congruential_prng_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .seed      (seed),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // Generator arithmetic
    // ------------------------------------------------------------------

    // A modulus register below 2 behaves as modulus 2.
    function automatic longint effective_modulus();
        longint m;
        m = longint'(mod_reg);
        if (m < 2)
            m = 2;
        return m;
    endfunction

    // Extended Euclid; the coefficient is taken even when the modulus is not
    // prime, and the inverse of zero is zero.
    function automatic longint inverse_mod(input longint x, input longint m);
        longint co   = 0;
        longint nco  = 1;
        longint rem  = m;
        longint nrem = x;
        longint q;
        longint tc;
        longint tr;
        if (x == 0)
            return 0;
        while (nrem != 0)
        begin
            q    = rem / nrem;
            tc   = co - q * nco;
            tr   = rem % nrem;
            co   = nco;
            nco  = tc;
            rem  = nrem;
            nrem = tr;
        end
        co = co % m;
        if (co < 0)
            co += m;
        return co;
    endfunction

    // One generator step; the state may lie above the modulus after a modulus change.
    function automatic logic [WORD_W-1:0] stepped_state(input logic [WORD_W-1:0] s);
        longint m;
        longint inv;
        longint prod;
        m    = effective_modulus();
        inv  = inverse_mod(longint'(s), m);
        prod = longint'(mult_reg) * inv + longint'(inc_reg);
        return WORD_W'(prod % m);
    endfunction

    task automatic predict_request(input logic [REQ_W-1:0] kind,
                                   input logic signed [SEED_W-1:0] s);
        longint m;
        longint r;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
        m = effective_modulus();
        case (kind)
            REQ_SEED:
            begin
                r = longint'(s) % m;
                if (r < 0)
                    r += m;
                gen_state = WORD_W'(r);
            end
            REQ_DRAW:
            begin
                gen_state = stepped_state(gen_state);
                expected_values.push_back(VALUE_W'(gen_state));
            end
            REQ_PAIR:
            begin
                hi        = stepped_state(gen_state);
                lo        = stepped_state(hi);
                gen_state = lo;
                expected_values.push_back({hi, 1'b0, lo});
            end
            default:
            begin
                // ignored code: state kept, nothing produced
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_request(input logic [REQ_W-1:0] kind,
                                input logic signed [SEED_W-1:0] s);
        request_t r;
        r.kind = kind;
        r.seed = s;
        request_queue.push_back(r);
        queued++;
    endtask

    function automatic logic signed [SEED_W-1:0] random_seed();
        logic [SEED_W-1:0] raw;
        case ($urandom_range(0, 5))
            0:       raw = 64'($urandom_range(0, 3000));
            1:       raw = -64'($urandom_range(1, 3000));
            2:       raw = {$urandom, $urandom};
            3:       raw = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
            4:       raw = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
            default: raw = 64'($urandom);
        endcase
        return raw;
    endfunction

    task automatic push_random_request();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 3)
            push_request(REQ_SEED, random_seed());
        else if (pick < 11)
            push_request(REQ_DRAW, {$urandom, $urandom});
        else if (pick < 19)
            push_request(REQ_PAIR, {$urandom, $urandom});
        else
            push_request(REQ_NONE, {$urandom, $urandom});
    endtask

    function automatic logic [WORD_W-1:0] pick_modulus();
        case ($urandom_range(0, 8))
            0:       return MODULUS_RST;
            1:       return 31'd2147483629;
            2:       return 31'd65521;
            3:       return 31'd251;
            4:       return 31'($urandom_range(0, 1));
            5:       return 31'($urandom_range(2, 1000));
            6:       return 31'($urandom);
            default: return 31'd7;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_multiplier();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 31'h7FFF_FFFF;
            2:       return MULT_RST;
            3:       return 31'($urandom_range(1, 100));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_increment();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 31'h7FFF_FFFF;
            2:       return INC_RST;
            default: return 31'($urandom);
        endcase
    endfunction

    // Hold until every queued request is taken and every result is back,
    // then let a trailing seed load run out.
    task automatic wait_idle();
        while (!(accepted == queued && expected_values.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register transfer; the copy is updated at the accepting edge.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [WORD_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            CFG_MODULUS:    mod_reg  = data;
            CFG_MULTIPLIER: mult_reg = data;
            CFG_INCREMENT:  inc_reg  = data;
            default:
            begin
                // unused index: nothing changes
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Request driver: changes inputs on the falling edge only.
    // ------------------------------------------------------------------
    int   tx_gap   = 0;
    logic tx_burst = 1'b0;

    always @(negedge clk)
    begin
        request_t r;
        if (rst_n)
        begin
            // After each transfer draw the pause before the next request;
            // now and then switch to a burst with no pauses at all.
            if (in_took)
            begin
                if ($urandom_range(0, 15) == 0)
                    tx_burst = !tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (in_valid && !in_took)
            begin
                // stalled: hold the payload as it stands
            end
            else if (tx_gap != 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (request_queue.size() != 0)
            begin
                r = request_queue.pop_front();
                in_valid <= 1'b1;
                req_type <= r.kind;
                seed     <= r.seed;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: draws a stall length per transfer, plus the long
    // hold-off that lets the block back up into its input.
    // ------------------------------------------------------------------
    int   rx_wait  = 3;
    logic rx_burst = 1'b0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_took)
            begin
                if ($urandom_range(0, 15) == 0)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (hold_off || rx_wait != 0)
            begin
                out_stall <= 1'b1;
                if (rx_wait != 0)
                    rx_wait--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Hold the result channel off for a long stretch once the sender has a
    // deep backlog, so that the block fills and stalls its input.
    initial
    begin
        while (!(results_seen >= 300 && request_queue.size() > 16))
            @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge, predict on each
    // accepted request and check each accepted result against the oldest
    // expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [VALUE_W-1:0] want;
        if (rst_n)
        begin
            in_took  <= in_valid && !in_stall;
            out_took <= out_valid && !out_stall;
            if (in_valid && !in_stall)
            begin
                accepted++;
                predict_request(req_type, seed);
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_values.size() == 0)
                    report_mismatch($sformatf("unexpected result value %h", value));
                else
                begin
                    want = expected_values.pop_front();
                    if (value !== want)
                        report_mismatch($sformatf("value got %h expected %h", value, want));
                end
            end
        end
    end

    // Watchdog: end the run if no channel moves a transfer for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed cases, then random phases over a range of
    // register settings.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings, state zero: the first draw inverts zero.
        push_request(REQ_DRAW, '0);
        push_request(REQ_PAIR, '0);
        push_request(REQ_SEED, 64'sh7FFF_FFFF_FFFF_FFFF);
        push_request(REQ_DRAW, '0);
        push_request(REQ_SEED, 64'sh8000_0000_0000_0000);
        push_request(REQ_PAIR, '0);
        push_request(REQ_SEED, -64'sd1);
        push_request(REQ_DRAW, '0);
        // Unused request code: nothing should come back and state stays.
        push_request(REQ_NONE, 64'sh5A5A_A5A5_0F0F_F0F0);
        push_request(REQ_DRAW, '0);
        // Seed equal to the modulus reduces to zero.
        push_request(REQ_SEED, 64'sd2147483647);
        push_request(REQ_DRAW, '0);
        wait_idle();

        // Degenerate modulus: zero and one both act as two.
        write_register(CFG_MODULUS, '0);
        push_request(REQ_SEED, -64'sd5);
        push_request(REQ_DRAW, '0);
        push_request(REQ_PAIR, '0);
        wait_idle();
        write_register(CFG_MODULUS, 31'd1);
        push_request(REQ_DRAW, '0);
        wait_idle();

        // Largest settings, then seed a state near the top of the range.
        write_register(CFG_MODULUS, 31'h7FFF_FFFF);
        write_register(CFG_MULTIPLIER, 31'h7FFF_FFFF);
        write_register(CFG_INCREMENT, 31'h7FFF_FFFF);
        push_request(REQ_SEED, 64'sh7FFF_FFFF_0000_1234);
        push_request(REQ_DRAW, '0);
        push_request(REQ_SEED, 64'sd2147483000);
        wait_idle();

        // Shrink the modulus below the held state; a composite modulus also
        // leaves some states with no true inverse.
        write_register(CFG_MODULUS, 31'd1000);
        write_register(CFG_INCREMENT, '0);
        push_request(REQ_DRAW, '0);
        push_request(REQ_PAIR, '0);
        wait_idle();
        write_register(CFG_MULTIPLIER, '0);
        write_register(CFG_INCREMENT, 31'd12345);
        push_request(REQ_DRAW, '0);
        wait_idle();

        // An unused register index must leave every setting alone.
        write_register(CFG_UNUSED, 31'h7FFF_FFFF);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            write_register(CFG_MODULUS, pick_modulus());
            write_register(CFG_MULTIPLIER, pick_multiplier());
            write_register(CFG_INCREMENT, pick_increment());
            push_request(REQ_SEED, random_seed());
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                push_random_request();
        end

        wait_idle();
        repeat (END_WAIT) @(posedge clk);
        if (expected_values.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_values.size()));
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
